@@ src/sfq_pkg.sv @@
// Shared types and constants for the searchable FIFO queue.
package sfq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int DATA_W          = 32;
    localparam int OCC_W           = 5;
    localparam int OP_W            = 2;
    localparam int STATUS_W        = 2;

    typedef enum logic [OP_W-1:0] {
        OP_ENQUEUE = 2'd0,
        OP_DEQUEUE = 2'd1,
        OP_UPDATE  = 2'd2,
        OP_SEARCH  = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    // Broadcast controls that every cell of the chain sees.
    typedef struct packed {
        logic enq;
        logic deq;
        logic upd;
    } t_cell_ctl;

endpackage

@@ src/sfq_cell.sv @@
// One storage cell of the queue chain: holds an entry, shifts towards the head, compares.
module sfq_cell import sfq_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int POS         = 0
) (
    input  logic                               i_clk,
    input  t_cell_ctl                          i_ctl,
    input  logic [$clog2(QUEUE_DEPTH+1)-1:0]   i_count,
    input  logic [$clog2(QUEUE_DEPTH)-1:0]     i_widx,
    input  logic [DATA_W-1:0]                  i_wdata,
    input  logic [DATA_W-1:0]                  i_key,
    input  logic [DATA_W-1:0]                  i_next_data,
    output logic [DATA_W-1:0]                  o_data,
    output logic                               o_match
);

    localparam int CW = $clog2(QUEUE_DEPTH+1);
    localparam int IW = $clog2(QUEUE_DEPTH);

    logic [DATA_W-1:0] r_data;
    logic              r_match;
    logic              w_held;

    assign w_held = CW'(POS) < i_count;

    always_ff @(posedge i_clk) begin
        if (i_ctl.deq) begin
            r_data <= i_next_data;
        end else if (i_ctl.enq && (i_count == CW'(POS))) begin
            r_data <= i_wdata;
        end else if (i_ctl.upd && (i_widx == IW'(POS))) begin
            r_data <= i_wdata;
        end
        r_match <= w_held && (r_data == i_key);
    end

    assign o_data  = r_data;
    assign o_match = r_match;

endmodule

@@ src/sfq_tree.sv @@
// Registered priority tree that picks the match nearest the head and carries its value.
module sfq_tree import sfq_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic [QUEUE_DEPTH-1:0]         i_match,
    input  logic [DATA_W-1:0]              i_val [QUEUE_DEPTH],
    output logic                           o_any,
    output logic [$clog2(QUEUE_DEPTH)-1:0] o_idx,
    output logic [DATA_W-1:0]              o_val
);

    localparam int LVLS = $clog2(QUEUE_DEPTH);
    localparam int LEAF = 1 << LVLS;

    logic              w_any [LEAF];
    logic [LVLS-1:0]   w_idx [LEAF];
    logic [DATA_W-1:0] w_val [LEAF];

    logic              r_any [1:LVLS][LEAF];
    logic [LVLS-1:0]   r_idx [1:LVLS][LEAF];
    logic [DATA_W-1:0] r_val [1:LVLS][LEAF];

    for (genvar j = 0; j < LEAF; j++) begin : g_leaf
        if (j < QUEUE_DEPTH) begin : g_real
            assign w_any[j] = i_match[j];
            assign w_val[j] = i_val[j];
        end else begin : g_pad
            assign w_any[j] = 1'b0;
            assign w_val[j] = '0;
        end
        assign w_idx[j] = LVLS'(j);
    end

    for (genvar k = 1; k <= LVLS; k++) begin : g_lvl
        for (genvar j = 0; j < (LEAF >> k); j++) begin : g_node
            if (k == 1) begin : g_first
                always_ff @(posedge i_clk) begin
                    r_any[k][j] <= w_any[2*j] | w_any[2*j+1];
                    r_idx[k][j] <= w_any[2*j] ? w_idx[2*j] : w_idx[2*j+1];
                    r_val[k][j] <= w_any[2*j] ? w_val[2*j] : w_val[2*j+1];
                end
            end else begin : g_upper
                // The lower half of the queue is nearer the head, so it wins.
                always_ff @(posedge i_clk) begin
                    r_any[k][j] <= r_any[k-1][2*j] | r_any[k-1][2*j+1];
                    r_idx[k][j] <= r_any[k-1][2*j] ? r_idx[k-1][2*j] : r_idx[k-1][2*j+1];
                    r_val[k][j] <= r_any[k-1][2*j] ? r_val[k-1][2*j] : r_val[k-1][2*j+1];
                end
            end
        end
    end

    assign o_any = r_any[LVLS][0];
    assign o_idx = r_idx[LVLS][0];
    assign o_val = r_val[LVLS][0];

endmodule

@@ src/searchable_fifo_queue_top.sv @@
// Top level of the searchable FIFO queue: cell chain, priority tree and operation control.
// Enqueue, dequeue and any operation on an empty queue: the result is registered as the item
// is taken; a new item is taken only while no result waits or the receiver takes it.
// Search and update: one compare stage in the cells, then the registered levels of the tree;
// the result is registered once the tree has resolved, and no item is taken while busy.
// Reset (synchronous, active low) empties the queue and drops the output valid; entries keep junk.
module searchable_fifo_queue_top import sfq_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [63:0]          s_axis_tdata,  // [31:0] item_value, [63:32] replacement
    input  logic [OP_W-1:0]      s_axis_tuser,  // [1:0] operation
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [39:0]          m_axis_tdata,  // [31:0] result_value, [36:32] occupancy
    output logic [STATUS_W-1:0]  m_axis_tuser   // [1:0] status
);

    localparam int CW   = $clog2(QUEUE_DEPTH+1);
    localparam int IW   = $clog2(QUEUE_DEPTH);
    localparam int TW   = $clog2(IW+2);

    typedef enum logic {
        ST_IDLE,
        ST_BUSY
    } t_state;

    t_state             r_state;
    logic [CW-1:0]      r_count;
    logic [TW-1:0]      r_wait;
    t_op                r_op;
    logic [DATA_W-1:0]  r_key;
    logic [DATA_W-1:0]  r_repl;
    logic               r_m_valid;
    t_status            r_status;
    logic [DATA_W-1:0]  r_value;
    logic [OCC_W-1:0]   r_occ;

    logic               w_accept;
    logic               w_finish;
    logic               w_full;
    logic               w_empty;
    t_op                w_op;
    t_cell_ctl          w_ctl;
    logic [DATA_W-1:0]  w_wdata;
    logic [DATA_W-1:0]  w_data  [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] w_match;
    logic               w_any;
    logic [IW-1:0]      w_idx;
    logic [DATA_W-1:0]  w_found;
    logic [CW-1:0]      n_count;
    logic [31:0]        w_occ_wide;

    assign w_op     = t_op'(s_axis_tuser);
    assign w_full   = r_count == CW'(QUEUE_DEPTH);
    assign w_empty  = r_count == '0;
    assign s_axis_tready = (r_state == ST_IDLE) && (!r_m_valid || m_axis_tready);
    assign w_accept = s_axis_tvalid && s_axis_tready;
    assign w_finish = (r_state == ST_BUSY) && (r_wait == '0);

    assign w_ctl.enq = w_accept && (w_op == OP_ENQUEUE) && !w_full;
    assign w_ctl.deq = w_accept && (w_op == OP_DEQUEUE) && !w_empty;
    assign w_ctl.upd = w_finish && (r_op == OP_UPDATE) && w_any;
    assign w_wdata   = (r_state == ST_BUSY) ? r_repl : s_axis_tdata[31:0];

    always_comb begin
        n_count = r_count;
        if (w_ctl.enq) begin
            n_count = r_count + 1'b1;
        end else if (w_ctl.deq) begin
            n_count = r_count - 1'b1;
        end
    end

    assign w_occ_wide = 32'(n_count);

    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        logic [DATA_W-1:0] w_next;
        if (i < QUEUE_DEPTH - 1) begin : g_mid
            assign w_next = w_data[i+1];
        end else begin : g_end
            assign w_next = w_data[i];
        end
        sfq_cell #(
            .QUEUE_DEPTH (QUEUE_DEPTH),
            .POS         (i)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_count     (r_count),
            .i_widx      (w_idx),
            .i_wdata     (w_wdata),
            .i_key       (r_key),
            .i_next_data (w_next),
            .o_data      (w_data[i]),
            .o_match     (w_match[i])
        );
    end

    sfq_tree #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_tree (
        .i_clk   (i_clk),
        .i_match (w_match),
        .i_val   (w_data),
        .o_any   (w_any),
        .o_idx   (w_idx),
        .o_val   (w_found)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_wait    <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_key  <= s_axis_tdata[31:0];
                        r_repl <= s_axis_tdata[63:32];
                        r_op   <= w_op;
                        r_occ  <= w_occ_wide[OCC_W-1:0];
                        if (w_op == OP_ENQUEUE) begin
                            r_status  <= w_full ? ST_FULL : ST_OK;
                            r_value   <= '0;
                            r_m_valid <= 1'b1;
                        end else if (w_empty) begin
                            r_status  <= ST_EMPTY;
                            r_value   <= '0;
                            r_m_valid <= 1'b1;
                        end else if (w_op == OP_DEQUEUE) begin
                            r_status  <= ST_OK;
                            r_value   <= w_data[0];
                            r_m_valid <= 1'b1;
                        end else begin
                            // Cells compare in the next cycle, then the tree resolves.
                            r_state   <= ST_BUSY;
                            r_wait    <= TW'(IW + 1);
                            r_m_valid <= 1'b0;
                        end
                    end else if (m_axis_tready) begin
                        r_m_valid <= 1'b0;
                    end
                end
                ST_BUSY: begin
                    if (w_finish) begin
                        r_state   <= ST_IDLE;
                        r_m_valid <= 1'b1;
                        r_status  <= w_any ? ST_OK : ST_NOT_FOUND;
                        r_value   <= (w_any && (r_op == OP_SEARCH)) ? w_found : '0;
                    end else begin
                        r_wait <= r_wait - 1'b1;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {3'b000, r_occ, r_value};
    assign m_axis_tuser  = r_status;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("queue occupancy beyond depth");

    a_busy_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_BUSY) |-> !s_axis_tready)
        else $error("item taken while a search is in progress");

    a_finish_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_finish |=> (m_axis_tvalid && (r_state == ST_IDLE)))
        else $error("search finished without a result");

    a_deq_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.deq |=> (r_count == $past(r_count) - 1'b1))
        else $error("dequeue did not lower the occupancy");

endmodule

@@ test/tb_top.sv @@
// Self-checking testbench for the searchable FIFO queue, with directed and random items.
module tb_top;
    import sfq_pkg::*;

    localparam int DEPTH       = QUEUE_DEPTH_DEF;
    localparam int IDX_W       = $clog2(DEPTH);
    localparam int RAND_ITEMS  = 1400;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_START  = 1500;
    localparam int HOLD_LEN    = 120;
    localparam int QUIET_FROM  = 3000;
    localparam int QUIET_TO    = 4500;
    localparam int DRAIN_WAIT  = 2 * IDX_W + 8;

    typedef struct packed {
        t_op              op;
        logic [DATA_W-1:0] value;
        logic [DATA_W-1:0] repl;
    } t_queue_item;

    typedef struct packed {
        t_status           status;
        logic [DATA_W-1:0] value;
        logic [OCC_W-1:0]  occ;
    } t_reply;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [63:0]         s_axis_tdata = '0;   // [31:0] item_value, [63:32] replacement
    logic [OP_W-1:0]     s_axis_tuser = '0;   // [1:0] operation
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [39:0]         m_axis_tdata;        // [31:0] result_value, [36:32] occupancy
    logic [STATUS_W-1:0] m_axis_tuser;        // [1:0] status

    t_queue_item op_backlog[$];
    t_reply      awaited_replies[$];

    // Shadow copy of the queue contents.
    logic [DATA_W-1:0] shadow_entries [DEPTH];
    logic [IDX_W-1:0]  shadow_head = '0;
    logic [IDX_W-1:0]  shadow_tail = '0;
    logic [OCC_W-1:0]  shadow_fill = '0;

    int  cycle_cnt    = 0;
    int  mismatch_cnt = 0;
    int  reply_cnt    = 0;
    int  hold_left    = 0;
    logic in_taken    = 1'b0;

    searchable_fifo_queue_top #(
        .QUEUE_DEPTH (DEPTH)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx);
        return (idx == IDX_W'(DEPTH - 1)) ? '0 : idx + 1'b1;
    endfunction

    // Half the values come from a small pool so that searches and updates often hit.
    function automatic logic [DATA_W-1:0] pick_value();
        logic [DATA_W-1:0] v;
        if ($urandom_range(0, 1) == 0) begin
            v = {$urandom};
        end else begin
            case ($urandom_range(0, 7))
                0: v = 32'h8000_0000;
                1: v = 32'h7FFF_FFFF;
                2: v = 32'h0000_0000;
                3: v = 32'hFFFF_FFFF;
                4: v = 32'h0000_0001;
                5: v = 32'h5A5A_5A5A;
                6: v = 32'hA5A5_A5A5;
                default: v = 32'h1234_5678;
            endcase
        end
        return v;
    endfunction

    task automatic push_item(input t_op op, input logic [DATA_W-1:0] value,
                             input logic [DATA_W-1:0] repl);
        t_queue_item it;
        it.op    = op;
        it.value = value;
        it.repl  = repl;
        op_backlog.push_back(it);
    endtask

    task automatic report_mismatch(input string what, input logic [39:0] want,
                                   input logic [39:0] got);
        $display("reply %0d: %s mismatch, expected %h, got %h", reply_cnt, what, want, got);
        mismatch_cnt++;
    endtask

    // Applies one accepted item to the shadow queue and records the reply it must give.
    task automatic compute_reply(input t_queue_item it);
        t_reply           r;
        logic [IDX_W-1:0] idx;
        bit               hit;
        r.status = ST_OK;
        r.value  = '0;
        hit      = 1'b0;
        idx      = shadow_head;
        case (it.op)
            OP_ENQUEUE: begin
                if (shadow_fill >= OCC_W'(DEPTH)) begin
                    r.status = ST_FULL;
                end else begin
                    shadow_entries[shadow_tail] = it.value;
                    shadow_tail = next_idx(shadow_tail);
                    shadow_fill = shadow_fill + 1'b1;
                end
            end
            OP_DEQUEUE: begin
                if (shadow_fill == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.value = shadow_entries[shadow_head];
                    shadow_head = next_idx(shadow_head);
                    shadow_fill = shadow_fill - 1'b1;
                end
            end
            default: begin
                if (shadow_fill == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    for (int i = 0; i < int'(shadow_fill) && !hit; i++) begin
                        if (shadow_entries[idx] == it.value) begin
                            hit = 1'b1;
                        end else begin
                            idx = next_idx(idx);
                        end
                    end
                    if (!hit) begin
                        r.status = ST_NOT_FOUND;
                    end else if (it.op == OP_UPDATE) begin
                        shadow_entries[idx] = it.repl;
                    end else begin
                        r.value = shadow_entries[idx];
                    end
                end
            end
        endcase
        r.occ = shadow_fill;
        awaited_replies.push_back(r);
    endtask

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    // Checks the result side first, then predicts from the item taken at this edge.
    always @(posedge i_clk) begin : watch_proc
        t_reply      want;
        t_queue_item seen;
        in_taken <= i_rst_n && s_axis_tvalid && s_axis_tready;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (awaited_replies.size() == 0) begin
                report_mismatch("unexpected item", '0, m_axis_tdata);
            end else begin
                want = awaited_replies.pop_front();
                if (m_axis_tuser !== want.status)
                    report_mismatch("status", 40'(want.status), 40'(m_axis_tuser));
                if (m_axis_tdata[31:0] !== want.value)
                    report_mismatch("value", 40'(want.value), 40'(m_axis_tdata[31:0]));
                if (m_axis_tdata[36:32] !== want.occ)
                    report_mismatch("occupancy", 40'(want.occ), 40'(m_axis_tdata[36:32]));
            end
            reply_cnt++;
        end
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            seen.op    = t_op'(s_axis_tuser);
            seen.value = s_axis_tdata[31:0];
            seen.repl  = s_axis_tdata[63:32];
            compute_reply(seen);
        end
    end

    always @(negedge i_clk) begin : drive_proc
        t_queue_item nxt;
        bit          idle;
        idle = !(cycle_cnt >= QUIET_FROM && cycle_cnt < QUIET_TO)
               && ($urandom_range(0, 99) < 21);
        if (i_rst_n && (!s_axis_tvalid || in_taken)) begin
            if (op_backlog.size() != 0 && !idle) begin
                nxt = op_backlog.pop_front();
                s_axis_tdata  <= {nxt.repl, nxt.value};
                s_axis_tuser  <= nxt.op;
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // The receiver stalls at random, and once for a long stretch so that the queue backs up.
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end else if (cycle_cnt == HOLD_START) begin
            m_axis_tready <= 1'b0;
            hold_left     <= HOLD_LEN;
        end else if (cycle_cnt >= QUIET_FROM && cycle_cnt < QUIET_TO) begin
            m_axis_tready <= 1'b1;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= 21);
        end
    end

    initial begin : watchdog
        while (cycle_cnt < CYCLE_LIMIT) @(posedge i_clk);
        $display("CHECK FAILED");
        $finish;
    end

    initial begin : run_proc
        int n;
        int burst;
        int mode;
        int roll;
        int enq_w;
        int deq_w;
        int upd_w;
        t_op op;

        // Operations on an empty queue.
        push_item(OP_DEQUEUE, 32'h0000_0000, 32'h0000_0000);
        push_item(OP_SEARCH, 32'h7FFF_FFFF, 32'h0000_0000);
        push_item(OP_UPDATE, 32'h8000_0000, 32'h0000_0001);
        // Extremes, with a duplicate so that only the first match is touched.
        push_item(OP_ENQUEUE, 32'h8000_0000, 32'hFFFF_FFFF);
        push_item(OP_ENQUEUE, 32'h7FFF_FFFF, 32'h0000_0000);
        push_item(OP_ENQUEUE, 32'h0000_0000, 32'h7FFF_FFFF);
        push_item(OP_ENQUEUE, 32'h7FFF_FFFF, 32'h8000_0000);
        push_item(OP_SEARCH, 32'h7FFF_FFFF, 32'h0000_0000);
        push_item(OP_SEARCH, 32'h0000_0005, 32'h0000_0000);
        push_item(OP_UPDATE, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        push_item(OP_SEARCH, 32'h7FFF_FFFF, 32'h0000_0000);
        push_item(OP_SEARCH, 32'hFFFF_FFFF, 32'h0000_0000);
        push_item(OP_UPDATE, 32'h0000_1234, 32'h0000_0000);
        // Fill to the brim, then one more that must be dropped.
        for (int i = 0; i < DEPTH - 4; i++) push_item(OP_ENQUEUE, {$urandom}, {$urandom});
        push_item(OP_ENQUEUE, 32'hDEAD_BEEF, 32'h0000_0000);
        push_item(OP_SEARCH, 32'h8000_0000, 32'h0000_0000);
        push_item(OP_DEQUEUE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_item(OP_DEQUEUE, 32'h0000_0000, 32'h0000_0000);

        // Bursts that lean towards filling, draining or a balanced mix.
        n = 0;
        while (n < RAND_ITEMS) begin
            mode  = $urandom_range(0, 2);
            burst = $urandom_range(8, 48);
            case (mode)
                0: begin enq_w = 65; deq_w = 10; upd_w = 12; end
                1: begin enq_w = 15; deq_w = 60; upd_w = 12; end
                default: begin enq_w = 25; deq_w = 25; upd_w = 25; end
            endcase
            for (int k = 0; k < burst && n < RAND_ITEMS; k++) begin
                roll = $urandom_range(0, 99);
                if (roll < enq_w)
                    op = OP_ENQUEUE;
                else if (roll < enq_w + deq_w)
                    op = OP_DEQUEUE;
                else if (roll < enq_w + deq_w + upd_w)
                    op = OP_UPDATE;
                else
                    op = OP_SEARCH;
                push_item(op, pick_value(), pick_value());
                n++;
            end
        end

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (op_backlog.size() != 0 || s_axis_tvalid) @(posedge i_clk);
        while (awaited_replies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatch_cnt == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
